>>> sv/lbts_pkg.sv
// Shared types and constants for the link block transfer sequencer.
`default_nettype none

package lbts_pkg;

   localparam int BLOCK_BYTES = 20;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [7:0] SEQ_MASK = 8'h7f;
   localparam logic [7:0] NAK_FLAG = 8'h80;

   // receive state codes
   localparam logic [7:0] RECV_IDLE   = 8'd0;
   localparam logic [7:0] RECV_ACTIVE = 8'd1;
   localparam logic [7:0] RECV_DONE   = 8'd2;

   // block kind codes
   localparam logic [7:0] KIND_NONE = 8'd0;
   localparam logic [7:0] KIND_MORE = 8'd1;
   localparam logic [7:0] KIND_LAST = 8'd2;

   // sequence value sent on a final handshake
   localparam logic [7:0] SEQ_FINAL = 8'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_START  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_LEN   = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_start;
      logic [ADDR_W-1:0] source_start;
      logic [LEN_W-1:0]  send_length;
   } cfg_type;

   typedef struct packed {
      logic       link_ready;
      logic       start_receive;
      logic       start_send;
      logic [7:0] peer_sequence;
      logic [7:0] peer_recv_state;
      logic [7:0] peer_send_kind;
   } item_type;

   typedef struct packed {
      logic [7:0]        own_sequence;
      logic [7:0]        own_status;
      logic [7:0]        own_recv_state;
      logic [7:0]        own_send_kind;
      logic              copy_in_enable;
      logic [ADDR_W-1:0] copy_in_address;
      logic              copy_out_enable;
      logic [ADDR_W-1:0] copy_out_address;
      logic [LEN_W-1:0]  received_bytes;
      logic              receive_busy;
      logic              send_busy;
   } result_type;

endpackage

`default_nettype wire

>>> sv/link_block_transfer_sequencer_unit.sv
// Top level of the link block transfer sequencer: word registers, config registers, core.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | link_ready, start flags, peer header bytes
//   rsp     | out       | rsp_valid/rsp_stall | own header bytes, copy enables/addresses, status
//   csr     | in        | csr_write           | csr_index, csr_data (no read-back)
//
// One word per cycle sustained while the output is not stalled; the state update runs while
// a word sits in the input register, and its result then moves to the output register.
// A stalled result stays in the output register; an empty input register takes one word.
// Synchronous active-high reset clears state, config and both valid flags.
`default_nettype none

module link_block_transfer_sequencer_unit import lbts_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [ADDR_W-1:0]     csr_data,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_link_ready,
   input  wire                  req_start_receive,
   input  wire                  req_start_send,
   input  wire [7:0]            req_peer_sequence,
   input  wire [7:0]            req_peer_recv_state,
   input  wire [7:0]            req_peer_send_kind,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [7:0]           rsp_own_sequence,
   output logic [7:0]           rsp_own_status,
   output logic [7:0]           rsp_own_recv_state,
   output logic [7:0]           rsp_own_send_kind,
   output logic                 rsp_copy_in_enable,
   output logic [ADDR_W-1:0]    rsp_copy_in_address,
   output logic                 rsp_copy_out_enable,
   output logic [ADDR_W-1:0]    rsp_copy_out_address,
   output logic [LEN_W-1:0]     rsp_received_bytes,
   output logic                 rsp_receive_busy,
   output logic                 rsp_send_busy
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   result_type step_result;
   logic       out_free, step, req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !step);
   assign out_valid_in  = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEST_START: cfg_ff.dest_start   <= csr_data;
            CSR_SRC_START:  cfg_ff.source_start <= csr_data;
            CSR_SEND_LEN:   cfg_ff.send_length  <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.link_ready      <= req_link_ready;
         item_ff.start_receive   <= req_start_receive;
         item_ff.start_send      <= req_start_send;
         item_ff.peer_sequence   <= req_peer_sequence;
         item_ff.peer_recv_state <= req_peer_recv_state;
         item_ff.peer_send_kind  <= req_peer_send_kind;
      end
      if (step) begin
         out_ff <= step_result;
      end
   end

   lbts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_own_sequence     = out_ff.own_sequence;
   assign rsp_own_status       = out_ff.own_status;
   assign rsp_own_recv_state   = out_ff.own_recv_state;
   assign rsp_own_send_kind    = out_ff.own_send_kind;
   assign rsp_copy_in_enable   = out_ff.copy_in_enable;
   assign rsp_copy_in_address  = out_ff.copy_in_address;
   assign rsp_copy_out_enable  = out_ff.copy_out_enable;
   assign rsp_copy_out_address = out_ff.copy_out_address;
   assign rsp_received_bytes   = out_ff.received_bytes;
   assign rsp_receive_busy     = out_ff.receive_busy;
   assign rsp_send_busy        = out_ff.send_busy;

endmodule

`default_nettype wire

>>> sv/lbts_core.sv
// Per-frame state update of the sequencer: pointers, counts, sequence and header bytes.
`default_nettype none

module lbts_core import lbts_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [ADDR_W-1:0] dest_ptr_ff, dest_ptr_in;
   logic [ADDR_W-1:0] src_ptr_ff, src_ptr_in;
   logic [LEN_W-1:0]  send_rem_ff, send_rem_in;
   logic [LEN_W-1:0]  recv_cnt_ff, recv_cnt_in;
   logic [7:0]        seq_cnt_ff, seq_cnt_in;
   logic [7:0]        out_seq_ff, out_seq_in;
   logic [7:0]        out_status_ff, out_status_in;
   logic [7:0]        out_recv_ff, out_recv_in;
   logic [7:0]        out_kind_ff, out_kind_in;

   logic              cin, cout;
   logic [ADDR_W-1:0] cin_addr, cout_addr;
   logic [6:0]        gap;
   logic [LEN_W-1:0]  gap_bytes;

   always_comb begin
      dest_ptr_in   = dest_ptr_ff;
      src_ptr_in    = src_ptr_ff;
      send_rem_in   = send_rem_ff;
      recv_cnt_in   = recv_cnt_ff;
      seq_cnt_in    = seq_cnt_ff;
      out_seq_in    = out_seq_ff;
      out_status_in = out_status_ff;
      out_recv_in   = out_recv_ff;
      out_kind_in   = out_kind_ff;
      cin       = 1'b0;
      cout      = 1'b0;
      cin_addr  = '0;
      cout_addr = '0;
      gap       = '0;
      gap_bytes = '0;

      if (item.start_receive) begin
         dest_ptr_in = cfg.dest_start;
         recv_cnt_in = '0;
      end
      if (item.start_send) begin
         src_ptr_in  = cfg.source_start;
         send_rem_in = cfg.send_length;
      end

      if (item.link_ready) begin
         // receive side
         if (dest_ptr_in != '0) begin
            if (out_recv_in == RECV_ACTIVE &&
                (item.peer_send_kind inside {KIND_MORE, KIND_LAST})) begin
               if (item.peer_sequence == (seq_cnt_in & SEQ_MASK)) begin
                  out_seq_in  = '0;
                  cin         = 1'b1;
                  cin_addr    = dest_ptr_in;
                  recv_cnt_in = recv_cnt_in + LEN_W'(BLOCK_BYTES);
                  if (item.peer_send_kind == KIND_MORE) begin
                     dest_ptr_in   = dest_ptr_in + ADDR_W'(BLOCK_BYTES);
                     out_status_in = (out_status_in + 8'd1) | NAK_FLAG;
                  end else begin
                     out_recv_in   = RECV_DONE;
                     out_status_in = '0;
                     out_seq_in    = SEQ_FINAL;
                  end
                  seq_cnt_in = (seq_cnt_in + 8'd1) & SEQ_MASK;
               end else if ((seq_cnt_in & NAK_FLAG) != '0) begin
                  if ((out_seq_in & NAK_FLAG) != '0) begin
                     out_seq_in = SEQ_FINAL;
                  end else if (out_seq_in == SEQ_FINAL) begin
                     out_seq_in = '0;
                     seq_cnt_in = seq_cnt_in & SEQ_MASK;
                  end
               end else begin
                  out_seq_in = seq_cnt_in | NAK_FLAG;
                  seq_cnt_in = seq_cnt_in | NAK_FLAG;
               end
            end else begin
               out_seq_in = '0;
            end
         end

         // send side
         if (src_ptr_in != '0) begin
            if (item.peer_recv_state == RECV_ACTIVE) begin
               if ((item.peer_sequence & NAK_FLAG) != '0) begin
                  gap         = 7'(seq_cnt_in - item.peer_sequence);
                  gap_bytes   = LEN_W'(gap * BLOCK_BYTES);
                  src_ptr_in  = src_ptr_in - ADDR_W'(gap_bytes);
                  send_rem_in = send_rem_in + gap_bytes;
                  seq_cnt_in  = (seq_cnt_in - {1'b0, gap}) & SEQ_MASK;
               end
               if (send_rem_in != '0) begin
                  cout        = 1'b1;
                  cout_addr   = src_ptr_in;
                  send_rem_in = send_rem_in - LEN_W'(BLOCK_BYTES);
                  out_kind_in = (send_rem_in != '0) ? KIND_MORE : KIND_LAST;
                  out_seq_in  = seq_cnt_in & SEQ_MASK;
                  src_ptr_in  = src_ptr_in + ADDR_W'(BLOCK_BYTES);
                  seq_cnt_in  = (seq_cnt_in + 8'd1) & SEQ_MASK;
               end
            end
            if (out_kind_in == KIND_LAST && item.peer_recv_state == RECV_DONE) begin
               src_ptr_in  = '0;
               out_kind_in = KIND_NONE;
               out_seq_in  = SEQ_FINAL;
            end
         end

         // receive handshake
         if (out_recv_in == RECV_DONE) begin
            if (item.peer_send_kind != KIND_LAST) begin
               dest_ptr_in = '0;
               out_recv_in = RECV_IDLE;
            end
         end else begin
            out_recv_in = (dest_ptr_in != '0) ? RECV_ACTIVE : RECV_IDLE;
         end
      end
   end

   always_comb begin
      result.own_sequence     = out_seq_in;
      result.own_status       = out_status_in;
      result.own_recv_state   = out_recv_in;
      result.own_send_kind    = out_kind_in;
      result.copy_in_enable   = cin;
      result.copy_in_address  = cin_addr;
      result.copy_out_enable  = cout;
      result.copy_out_address = cout_addr;
      result.received_bytes   = recv_cnt_in;
      result.receive_busy     = (dest_ptr_in != '0);
      result.send_busy        = (src_ptr_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ptr_ff   <= '0;
         src_ptr_ff    <= '0;
         send_rem_ff   <= '0;
         recv_cnt_ff   <= '0;
         seq_cnt_ff    <= '0;
         out_seq_ff    <= '0;
         out_status_ff <= '0;
         out_recv_ff   <= '0;
         out_kind_ff   <= '0;
      end else if (step) begin
         dest_ptr_ff   <= dest_ptr_in;
         src_ptr_ff    <= src_ptr_in;
         send_rem_ff   <= send_rem_in;
         recv_cnt_ff   <= recv_cnt_in;
         seq_cnt_ff    <= seq_cnt_in;
         out_seq_ff    <= out_seq_in;
         out_status_ff <= out_status_in;
         out_recv_ff   <= out_recv_in;
         out_kind_ff   <= out_kind_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/lbts_checker.sv
// Port-level assertions for the sequencer and their bind to the top level.
`default_nettype none

module lbts_checker import lbts_pkg::*; (
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire [7:0]           rsp_own_send_kind,
   input wire                 rsp_copy_in_enable,
   input wire [ADDR_W-1:0]    rsp_copy_in_address,
   input wire                 rsp_copy_out_enable,
   input wire [ADDR_W-1:0]    rsp_copy_out_address
);

   a_no_word_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_cin_addr_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_copy_in_enable) |-> (rsp_copy_in_address == '0))
      else $error("copy-in address set without copy-in");

   a_cout_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_copy_out_enable) |->
      (rsp_own_send_kind == KIND_MORE || rsp_own_send_kind == KIND_LAST))
      else $error("block sent without a block kind");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_copy_out_address) && $stable(rsp_copy_out_enable)))
      else $error("stalled result word changed");

endmodule

bind link_block_transfer_sequencer_unit lbts_checker u_lbts_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the link block transfer sequencer: directed handshakes, then random traffic.
`timescale 1ns / 100ps

module testbench;
   import lbts_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES        = 4;
   localparam int SEGMENTS      = 6;
   localparam int SEG_WORDS     = 73;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_link_ready = 1'b0;
   logic                 req_start_receive = 1'b0;
   logic                 req_start_send = 1'b0;
   logic [7:0]           req_peer_sequence = '0;
   logic [7:0]           req_peer_recv_state = '0;
   logic [7:0]           req_peer_send_kind = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_own_sequence;
   logic [7:0]           rsp_own_status;
   logic [7:0]           rsp_own_recv_state;
   logic [7:0]           rsp_own_send_kind;
   logic                 rsp_copy_in_enable;
   logic [ADDR_W-1:0]    rsp_copy_in_address;
   logic                 rsp_copy_out_enable;
   logic [ADDR_W-1:0]    rsp_copy_out_address;
   logic [LEN_W-1:0]     rsp_received_bytes;
   logic                 rsp_receive_busy;
   logic                 rsp_send_busy;

   link_block_transfer_sequencer_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_link_ready       (req_link_ready),
      .req_start_receive    (req_start_receive),
      .req_start_send       (req_start_send),
      .req_peer_sequence    (req_peer_sequence),
      .req_peer_recv_state  (req_peer_recv_state),
      .req_peer_send_kind   (req_peer_send_kind),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_own_sequence     (rsp_own_sequence),
      .rsp_own_status       (rsp_own_status),
      .rsp_own_recv_state   (rsp_own_recv_state),
      .rsp_own_send_kind    (rsp_own_send_kind),
      .rsp_copy_in_enable   (rsp_copy_in_enable),
      .rsp_copy_in_address  (rsp_copy_in_address),
      .rsp_copy_out_enable  (rsp_copy_out_enable),
      .rsp_copy_out_address (rsp_copy_out_address),
      .rsp_received_bytes   (rsp_received_bytes),
      .rsp_receive_busy     (rsp_receive_busy),
      .rsp_send_busy        (rsp_send_busy)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // link state mirror
   cfg_type          shadow_cfg;
   logic [31:0]      rx_dest_ptr;
   logic [31:0]      tx_src_ptr;
   logic [15:0]      tx_left;
   logic [15:0]      rx_bytes;
   logic [7:0]       link_seq;
   logic [7:0]       hdr_seq;
   logic [7:0]       hdr_status;
   logic [7:0]       hdr_rx_state;
   logic [7:0]       hdr_tx_kind;

   result_type       pending_frames[$];
   int               idle_pct = 25;
   int               stall_pct = 25;
   int               error_count = 0;
   int               frames_checked = 0;
   int               words_sent = 0;
   int               blocks_in = 0;
   int               blocks_out = 0;
   int               config_sets = 0;
   int               quiet_cycles = 0;

   function automatic result_type next_frame_result(input item_type w);
      result_type r;
      logic [31:0] gap;
      r = '0;
      if (w.start_receive) begin
         rx_dest_ptr = shadow_cfg.dest_start;
         rx_bytes = '0;
      end
      if (w.start_send) begin
         tx_src_ptr = shadow_cfg.source_start;
         tx_left = shadow_cfg.send_length;
      end
      if (w.link_ready) begin
         if (rx_dest_ptr != 0) begin
            if (hdr_rx_state == RECV_ACTIVE &&
                (w.peer_send_kind == KIND_MORE || w.peer_send_kind == KIND_LAST)) begin
               if (w.peer_sequence == (link_seq & SEQ_MASK)) begin
                  hdr_seq = '0;
                  r.copy_in_enable = 1'b1;
                  r.copy_in_address = rx_dest_ptr;
                  rx_bytes = rx_bytes + 16'(BLOCK_BYTES);
                  if (w.peer_send_kind == KIND_MORE) begin
                     rx_dest_ptr = rx_dest_ptr + 32'(BLOCK_BYTES);
                     hdr_status = (hdr_status + 8'd1) | NAK_FLAG;
                  end else begin
                     hdr_rx_state = RECV_DONE;
                     hdr_status = '0;
                     hdr_seq = SEQ_FINAL;
                  end
                  link_seq = (link_seq + 8'd1) & SEQ_MASK;
               end else if ((link_seq & NAK_FLAG) != 0) begin
                  if ((hdr_seq & NAK_FLAG) != 0) begin
                     hdr_seq = SEQ_FINAL;
                  end else if (hdr_seq == SEQ_FINAL) begin
                     hdr_seq = '0;
                     link_seq = link_seq & SEQ_MASK;
                  end
               end else begin
                  hdr_seq = link_seq | NAK_FLAG;
                  link_seq = link_seq | NAK_FLAG;
               end
            end else begin
               hdr_seq = '0;
            end
         end
         if (tx_src_ptr != 0) begin
            if (w.peer_recv_state == RECV_ACTIVE) begin
               if ((w.peer_sequence & NAK_FLAG) != 0) begin
                  gap = {24'd0, (link_seq - w.peer_sequence) & SEQ_MASK};
                  tx_src_ptr = tx_src_ptr - gap * 32'(BLOCK_BYTES);
                  tx_left = 16'(tx_left + gap * 32'(BLOCK_BYTES));
                  link_seq = (link_seq - gap[7:0]) & SEQ_MASK;
               end
               if (tx_left != 0) begin
                  r.copy_out_enable = 1'b1;
                  r.copy_out_address = tx_src_ptr;
                  tx_left = tx_left - 16'(BLOCK_BYTES);
                  hdr_tx_kind = (tx_left != 0) ? KIND_MORE : KIND_LAST;
                  hdr_seq = link_seq & SEQ_MASK;
                  tx_src_ptr = tx_src_ptr + 32'(BLOCK_BYTES);
                  link_seq = (link_seq + 8'd1) & SEQ_MASK;
               end
            end
            if (hdr_tx_kind == KIND_LAST && w.peer_recv_state == RECV_DONE) begin
               tx_src_ptr = '0;
               hdr_tx_kind = KIND_NONE;
               hdr_seq = SEQ_FINAL;
            end
         end
         if (hdr_rx_state == RECV_DONE) begin
            if (w.peer_send_kind != KIND_LAST) begin
               rx_dest_ptr = '0;
               hdr_rx_state = RECV_IDLE;
            end
         end else begin
            hdr_rx_state = (rx_dest_ptr != 0) ? RECV_ACTIVE : RECV_IDLE;
         end
      end
      r.own_sequence = hdr_seq;
      r.own_status = hdr_status;
      r.own_recv_state = hdr_rx_state;
      r.own_send_kind = hdr_tx_kind;
      r.received_bytes = rx_bytes;
      r.receive_busy = (rx_dest_ptr != 0);
      r.send_busy = (tx_src_ptr != 0);
      return r;
   endfunction

   function automatic item_type build_word(input logic ready, input logic srx, input logic stx,
                                           input logic [7:0] seq, input logic [7:0] rstate,
                                           input logic [7:0] kind);
      item_type w;
      w.link_ready = ready;
      w.start_receive = srx;
      w.start_send = stx;
      w.peer_sequence = seq;
      w.peer_recv_state = rstate;
      w.peer_send_kind = kind;
      return w;
   endfunction

   // biased toward well-formed peer behavior, using the mirrored sequence counter
   function automatic item_type random_word();
      item_type w;
      int pick;
      w.link_ready = ($urandom_range(99) < 94);
      w.start_receive = ($urandom_range(99) < ((rx_dest_ptr == 0) ? 15 : 2));
      w.start_send = ($urandom_range(99) < ((tx_src_ptr == 0) ? 15 : 2));
      pick = $urandom_range(99);
      if (pick < 55)
         w.peer_sequence = link_seq & SEQ_MASK;
      else if (pick < 70)
         w.peer_sequence = NAK_FLAG | ((link_seq - 8'($urandom_range(3))) & SEQ_MASK);
      else if (pick < 80)
         w.peer_sequence = (link_seq + 8'($urandom_range(1, 4))) & SEQ_MASK;
      else
         w.peer_sequence = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 70)
         w.peer_recv_state = RECV_ACTIVE;
      else if (pick < 85)
         w.peer_recv_state = RECV_DONE;
      else
         w.peer_recv_state = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 55)
         w.peer_send_kind = KIND_MORE;
      else if (pick < 75)
         w.peer_send_kind = KIND_LAST;
      else if (pick < 85)
         w.peer_send_kind = KIND_NONE;
      else
         w.peer_send_kind = 8'($urandom);
      return w;
   endfunction

   task automatic send_word(input item_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_link_ready <= w.link_ready;
      req_start_receive <= w.start_receive;
      req_start_send <= w.start_send;
      req_peer_sequence <= w.peer_sequence;
      req_peer_recv_state <= w.peer_recv_state;
      req_peer_send_kind <= w.peer_send_kind;
      do @(posedge clock); while (req_stall);
      pending_frames.push_back(next_frame_result(w));
      words_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_DEST_START: shadow_cfg.dest_start = val;
         CSR_SRC_START:  shadow_cfg.source_start = val;
         CSR_SEND_LEN:   shadow_cfg.send_length = val[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_config(input logic [31:0] dest, input logic [31:0] src,
                                 input logic [15:0] len);
      pause_until_drained();
      write_csr(CSR_DEST_START, dest);
      write_csr(CSR_SRC_START, src);
      write_csr(CSR_SEND_LEN, {16'd0, len});
      csr_write <= 1'b0;
      config_sets++;
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s, frame %0d: expected %0h, got %0h",
                     name, frames_checked, want, got);
      end
   endfunction

   task automatic check_frame();
      result_type want;
      if (pending_frames.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("result word with no frame pending");
      end else begin
         want = pending_frames.pop_front();
         compare_field("own_sequence", want.own_sequence, rsp_own_sequence);
         compare_field("own_status", want.own_status, rsp_own_status);
         compare_field("own_recv_state", want.own_recv_state, rsp_own_recv_state);
         compare_field("own_send_kind", want.own_send_kind, rsp_own_send_kind);
         compare_field("copy_in_enable", want.copy_in_enable, rsp_copy_in_enable);
         compare_field("copy_in_address", want.copy_in_address, rsp_copy_in_address);
         compare_field("copy_out_enable", want.copy_out_enable, rsp_copy_out_enable);
         compare_field("copy_out_address", want.copy_out_address, rsp_copy_out_address);
         compare_field("received_bytes", want.received_bytes, rsp_received_bytes);
         compare_field("receive_busy", want.receive_busy, rsp_receive_busy);
         compare_field("send_busy", want.send_busy, rsp_send_busy);
         if (want.copy_in_enable) blocks_in++;
         if (want.copy_out_enable) blocks_out++;
      end
      frames_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_frame();
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_link_down();
      program_config('1, '1, '1);
      send_word(build_word(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
      send_word(build_word(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
      send_word(build_word(1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
   endtask

   // accept, NAK and recover, pointer wrap to zero, then last-block handshake
   task automatic test_receive_handshake();
      program_config(32'hFFFF_FFD8, '0, '0);
      send_word(build_word(1'b1, 1'b1, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_MORE));
      repeat (3)
         send_word(build_word(1'b1, 1'b0, 1'b0, (link_seq + 8'd5) & SEQ_MASK,
                              RECV_IDLE, KIND_MORE));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_MORE));
      send_word(build_word(1'b1, 1'b1, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_LAST));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_LAST));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_IDLE, KIND_NONE));
   endtask

   // send with a two-block rewind, finish on peer done, then an odd length that wraps
   task automatic test_send_rewind();
      program_config('0, 32'h0000_1000, 16'd60);
      send_word(build_word(1'b1, 1'b0, 1'b1, link_seq & SEQ_MASK, RECV_ACTIVE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_ACTIVE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, NAK_FLAG | ((link_seq - 8'd2) & SEQ_MASK),
                           RECV_ACTIVE, KIND_NONE));
      repeat (3)
         send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_ACTIVE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, link_seq & SEQ_MASK, RECV_DONE, KIND_NONE));
      program_config('0, 32'h0000_0010, 16'd7);
      send_word(build_word(1'b1, 1'b0, 1'b1, link_seq & SEQ_MASK, RECV_ACTIVE, KIND_NONE));
      send_word(build_word(1'b1, 1'b0, 1'b0, NAK_FLAG | (link_seq & SEQ_MASK),
                           RECV_ACTIVE, KIND_NONE));
   endtask

   task automatic test_random_traffic();
      int          idle_by_phase [PHASES] = '{0, 87, 0, 8};
      int          stall_by_phase [PHASES] = '{0, 0, 87, 8};
      logic [31:0] dest;
      logic [31:0] src;
      logic [15:0] len;
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         for (int s = 0; s < SEGMENTS; s++) begin
            if (s == 0) begin
               program_config('1, '1, '1);
            end else if (s == 1) begin
               program_config('0, '0, '0);
            end else begin
               dest = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
               src = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
               len = ($urandom_range(4) == 0) ? 16'($urandom)
                                              : 16'(BLOCK_BYTES * $urandom_range(1, 6));
               program_config(dest, src, len);
            end
            for (int k = 0; k < SEG_WORDS; k++) begin
               if (s == 2 && k == SEG_WORDS / 2) pause_until_drained();
               send_word(random_word());
            end
         end
      end
   endtask

   initial begin
      shadow_cfg = '0;
      rx_dest_ptr = '0;
      tx_src_ptr = '0;
      tx_left = '0;
      rx_bytes = '0;
      link_seq = '0;
      hdr_seq = '0;
      hdr_status = '0;
      hdr_rx_state = RECV_IDLE;
      hdr_tx_kind = KIND_NONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_link_down();
      test_receive_handshake();
      test_send_rewind();
      test_random_traffic();
      pause_until_drained();
      $display("%0d words sent, %0d frames checked over %0d register settings",
               words_sent, frames_checked, config_sets);
      $display("%0d blocks copied in, %0d blocks copied out, %0d errors",
               blocks_in, blocks_out, error_count);
      if (error_count == 0 && pending_frames.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
sv/lbts_pkg.sv
sv/lbts_core.sv
sv/link_block_transfer_sequencer_unit.sv
sv/lbts_checker.sv
dv/testbench.sv
